[src/tfn_pkg.sv]
// ----------------------------------------------------------------------------
// Triangle face normal package
// Transfer types and pipeline constants shared by the face normal core and
// its port checker.
// ----------------------------------------------------------------------------
`default_nettype none

package tfn_pkg;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned DiffW    = CoordW + 1;
  localparam int unsigned ProdW    = 2 * DiffW;
  localparam int unsigned MagW     = ProdW;
  localparam int unsigned HalfW    = MagW / 2;
  localparam int unsigned SqW      = 2 * MagW;
  localparam int unsigned DivSteps = 30;
  localparam int unsigned QuoW     = DivSteps + 1;
  localparam int unsigned RadW     = 32;
  localparam int unsigned RootW    = RadW / 2;
  localparam int unsigned SrRemW   = RootW + 2;
  localparam int unsigned SrCurW   = SrRemW + 2;
  localparam int unsigned OutW     = 16;
  localparam int unsigned OneQ14   = 16384;

  typedef struct packed {
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic signed [CoordW-1:0] a_z;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic signed [CoordW-1:0] b_z;
    logic signed [CoordW-1:0] c_x;
    logic signed [CoordW-1:0] c_y;
    logic signed [CoordW-1:0] c_z;
  } in_t;

  typedef struct packed {
    logic signed [OutW-1:0] normal_x;
    logic signed [OutW-1:0] normal_y;
    logic signed [OutW-1:0] normal_z;
    logic                   degenerate;
  } out_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } side_t;

endpackage

`default_nettype wire

[src/triangle_face_normal_core.sv]
// ----------------------------------------------------------------------------
// Triangle face normal core
// Throughput is one triangle per cycle; the whole pipeline holds while the
// output register is full and stalled, so nothing is lost or repeated.
// Reset clears every stage valid bit and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_face_normal_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire tfn_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output tfn_pkg::out_t      out_data_o
);

  localparam int unsigned DivFirst  = 6;
  localparam int unsigned SqrtFirst = DivFirst + tfn_pkg::DivSteps + 1;
  localparam int unsigned LastStage = SqrtFirst + tfn_pkg::RootW - 1;

  logic adv;
  logic valid_q [LastStage+1];
  tfn_pkg::side_t side_q [2:LastStage];
  logic out_valid_q;
  tfn_pkg::out_t out_data_q;

  assign adv         = ~out_valid_q | ~out_stall_i;
  assign in_stall_o  = ~adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= LastStage; j++) valid_q[j] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      valid_q[0] <= in_valid_i;
      for (int j = 1; j <= LastStage; j++) valid_q[j] <= valid_q[j-1];
      out_valid_q <= valid_q[LastStage];
    end
  end

  // Edge vectors.
  logic signed [tfn_pkg::DiffW-1:0] u_q [3];
  logic signed [tfn_pkg::DiffW-1:0] v_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      u_q[0] <= {in_data_i.b_x[15], in_data_i.b_x} - {in_data_i.a_x[15], in_data_i.a_x};
      u_q[1] <= {in_data_i.b_y[15], in_data_i.b_y} - {in_data_i.a_y[15], in_data_i.a_y};
      u_q[2] <= {in_data_i.b_z[15], in_data_i.b_z} - {in_data_i.a_z[15], in_data_i.a_z};
      v_q[0] <= {in_data_i.c_x[15], in_data_i.c_x} - {in_data_i.a_x[15], in_data_i.a_x};
      v_q[1] <= {in_data_i.c_y[15], in_data_i.c_y} - {in_data_i.a_y[15], in_data_i.a_y};
      v_q[2] <= {in_data_i.c_z[15], in_data_i.c_z} - {in_data_i.a_z[15], in_data_i.a_z};
    end
  end

  // Cross product terms.
  logic signed [tfn_pkg::ProdW-1:0] p_q [6];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q[0] <= u_q[1] * v_q[2];
      p_q[1] <= u_q[2] * v_q[1];
      p_q[2] <= u_q[2] * v_q[0];
      p_q[3] <= u_q[0] * v_q[2];
      p_q[4] <= u_q[0] * v_q[1];
      p_q[5] <= u_q[1] * v_q[0];
    end
  end

  // Cross product components as magnitude and sign.
  logic signed [tfn_pkg::ProdW:0] n_d [3];
  logic [tfn_pkg::ProdW:0]        nmag_d [3];
  logic [tfn_pkg::MagW-1:0]       m_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_d[i] = {p_q[2*i][tfn_pkg::ProdW-1], p_q[2*i]}
             - {p_q[2*i+1][tfn_pkg::ProdW-1], p_q[2*i+1]};
      nmag_d[i] = n_d[i][tfn_pkg::ProdW] ? (~n_d[i] + 1'b1) : n_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        m_q[i]           <= nmag_d[i][tfn_pkg::MagW-1:0];
        side_q[2].neg[i] <= n_d[i][tfn_pkg::ProdW];
      end
      side_q[2].degen <= (n_d[0] == '0) && (n_d[1] == '0) && (n_d[2] == '0);
      for (int j = 3; j <= LastStage; j++) side_q[j] <= side_q[j-1];
    end
  end

  // Squares in halves.
  logic [tfn_pkg::MagW-1:0] ll_q [3];
  logic [tfn_pkg::MagW-1:0] lh_q [3];
  logic [tfn_pkg::MagW-1:0] hh_q [3];
  logic [tfn_pkg::SqW-1:0]  sq_q [3];
  logic [tfn_pkg::SqW-1:0]  sq2_q [3];
  logic [tfn_pkg::SqW-1:0]  s_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ll_q[i] <= m_q[i][tfn_pkg::HalfW-1:0] * m_q[i][tfn_pkg::HalfW-1:0];
        lh_q[i] <= m_q[i][tfn_pkg::HalfW-1:0] * m_q[i][tfn_pkg::MagW-1:tfn_pkg::HalfW];
        hh_q[i] <= m_q[i][tfn_pkg::MagW-1:tfn_pkg::HalfW]
                 * m_q[i][tfn_pkg::MagW-1:tfn_pkg::HalfW];
        sq_q[i] <= ({hh_q[i], {tfn_pkg::MagW{1'b0}}})
                 + ({{(tfn_pkg::HalfW-1){1'b0}}, lh_q[i], {(tfn_pkg::HalfW+1){1'b0}}})
                 + ({{tfn_pkg::MagW{1'b0}}, ll_q[i]});
        sq2_q[i] <= sq_q[i];
      end
      s_q <= sq_q[0] + sq_q[1] + sq_q[2];
    end
  end

  // Long division of each square by the sum of squares, one bit per stage.
  logic [tfn_pkg::SqW-1:0]  dr_q [tfn_pkg::DivSteps+1][3];
  logic [tfn_pkg::QuoW-1:0] dq_q [tfn_pkg::DivSteps+1][3];
  logic [tfn_pkg::SqW-1:0]  ds_q [tfn_pkg::DivSteps+1];
  logic [tfn_pkg::SqW:0]    dcur_d [tfn_pkg::DivSteps+1][3];
  logic                     dge_d [tfn_pkg::DivSteps+1][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dcur_d[0][i] = {1'b0, sq2_q[i]};
      dge_d[0][i]  = sq2_q[i] >= s_q;
      for (int j = 1; j <= tfn_pkg::DivSteps; j++) begin
        dcur_d[j][i] = {dr_q[j-1][i], 1'b0};
        dge_d[j][i]  = dcur_d[j][i] >= {1'b0, ds_q[j-1]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ds_q[0] <= s_q;
      for (int i = 0; i < 3; i++) begin
        dr_q[0][i] <= dge_d[0][i] ? (sq2_q[i] - s_q) : sq2_q[i];
        dq_q[0][i] <= {{(tfn_pkg::QuoW-1){1'b0}}, dge_d[0][i]};
      end
      for (int j = 1; j <= tfn_pkg::DivSteps; j++) begin
        ds_q[j] <= ds_q[j-1];
        for (int i = 0; i < 3; i++) begin
          dr_q[j][i] <= dge_d[j][i]
                      ? tfn_pkg::SqW'(dcur_d[j][i] - {1'b0, ds_q[j-1]})
                      : tfn_pkg::SqW'(dcur_d[j][i]);
          dq_q[j][i] <= {dq_q[j-1][i][tfn_pkg::QuoW-2:0], dge_d[j][i]};
        end
      end
    end
  end

  // Integer square root of the quotient, one root bit per stage.
  logic [tfn_pkg::RadW-1:0]   sr_rad_q [tfn_pkg::RootW][3];
  logic [tfn_pkg::SrRemW-1:0] sr_rem_q [tfn_pkg::RootW][3];
  logic [tfn_pkg::RootW-1:0]  sr_root_q [tfn_pkg::RootW][3];
  logic [tfn_pkg::RadW-1:0]   sr_rad_in [tfn_pkg::RootW][3];
  logic [tfn_pkg::SrRemW-1:0] sr_rem_in [tfn_pkg::RootW][3];
  logic [tfn_pkg::RootW-1:0]  sr_root_in [tfn_pkg::RootW][3];
  logic [tfn_pkg::SrCurW-1:0] sr_cur_d [tfn_pkg::RootW][3];
  logic [tfn_pkg::SrCurW-1:0] sr_try_d [tfn_pkg::RootW][3];
  logic                       sr_ge_d [tfn_pkg::RootW][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sr_rad_in[0][i]  = {1'b0, dq_q[tfn_pkg::DivSteps][i]};
      sr_rem_in[0][i]  = '0;
      sr_root_in[0][i] = '0;
      for (int j = 1; j < tfn_pkg::RootW; j++) begin
        sr_rad_in[j][i]  = sr_rad_q[j-1][i];
        sr_rem_in[j][i]  = sr_rem_q[j-1][i];
        sr_root_in[j][i] = sr_root_q[j-1][i];
      end
      for (int j = 0; j < tfn_pkg::RootW; j++) begin
        sr_cur_d[j][i] = {sr_rem_in[j][i], sr_rad_in[j][i][tfn_pkg::RadW-1 -: 2]};
        sr_try_d[j][i] = {2'b00, sr_root_in[j][i], 2'b01};
        sr_ge_d[j][i]  = sr_cur_d[j][i] >= sr_try_d[j][i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < tfn_pkg::RootW; j++) begin
        for (int i = 0; i < 3; i++) begin
          sr_rad_q[j][i]  <= {sr_rad_in[j][i][tfn_pkg::RadW-3:0], 2'b00};
          sr_rem_q[j][i]  <= sr_ge_d[j][i]
                           ? tfn_pkg::SrRemW'(sr_cur_d[j][i] - sr_try_d[j][i])
                           : tfn_pkg::SrRemW'(sr_cur_d[j][i]);
          sr_root_q[j][i] <= {sr_root_in[j][i][tfn_pkg::RootW-2:0], sr_ge_d[j][i]};
        end
      end
    end
  end

  // Round to the nearest odd bound and apply the sign.
  logic [tfn_pkg::RootW:0]  k_sum_d [3];
  logic [tfn_pkg::OutW-1:0] comp_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      k_sum_d[i] = {1'b0, sr_root_q[tfn_pkg::RootW-1][i]} + 1'b1;
      if (side_q[LastStage].degen) begin
        comp_d[i] = '0;
      end else if (side_q[LastStage].neg[i]) begin
        comp_d[i] = ~k_sum_d[i][tfn_pkg::RootW:1] + 1'b1;
      end else begin
        comp_d[i] = k_sum_d[i][tfn_pkg::RootW:1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q.normal_x   <= comp_d[0];
      out_data_q.normal_y   <= comp_d[1];
      out_data_q.normal_z   <= comp_d[2];
      out_data_q.degenerate <= side_q[LastStage].degen;
    end
  end

endmodule

`default_nettype wire

[src/tfn_port_checker.sv]
// ----------------------------------------------------------------------------
// Triangle face normal port checker
// Watches the ports of the face normal core and checks output ranges,
// degenerate results, input stalls and the hold behavior of the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_port_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire tfn_pkg::out_t out_data_o,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i
);

  localparam logic signed [tfn_pkg::OutW-1:0] PosOne = tfn_pkg::OutW'(tfn_pkg::OneQ14);
  localparam logic signed [tfn_pkg::OutW-1:0] NegOne = -PosOne;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled result changed.");

  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("Input stalled without a stalled result.");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.normal_x == '0 && out_data_o.normal_y == '0 && out_data_o.normal_z == '0)
    else $error("Degenerate result with nonzero normal.");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      $signed(out_data_o.normal_x) <= PosOne && $signed(out_data_o.normal_x) >= NegOne &&
      $signed(out_data_o.normal_y) <= PosOne && $signed(out_data_o.normal_y) >= NegOne &&
      $signed(out_data_o.normal_z) <= PosOne && $signed(out_data_o.normal_z) >= NegOne)
    else $error("Normal component out of range.");

  a_nondegen_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.degenerate && in_valid_i |->
      out_data_o.normal_x != '0 || out_data_o.normal_y != '0 || out_data_o.normal_z != '0)
    else $error("Unit normal is all zeros.");

endmodule

bind triangle_face_normal_core tfn_port_checker u_tfn_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_data_o  (out_data_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);

`default_nettype wire

[dv/triangle_face_normal_core_tb.sv]
// ----------------------------------------------------------------------------
// Triangle face normal core testbench
// Drives triangles through the input channel with random gaps and random
// output stalls. Every accepted transfer is predicted with exact integer
// arithmetic, and every output transfer is checked field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_face_normal_core_tb;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainWait  = 80;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  tfn_pkg::in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  tfn_pkg::out_t out_data_o;

  tfn_pkg::out_t pending_normals[$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   stall_left = 0;
  bit            stall_quiet = 1'b0;
  bit            gap_quiet = 1'b0;

  triangle_face_normal_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [15:0] unit_component(longint n, logic [127:0] len_sq);
    logic [127:0] mag;
    logic [127:0] rhs;
    logic [127:0] odd;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  mid;
    mag = (n < 0) ? 128'(-n) : 128'(n);
    rhs = (mag * mag) << 30;
    lo = 0;
    hi = tfn_pkg::OneQ14;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      odd = 128'(2 * mid - 1);
      if (len_sq * odd * odd <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return (n < 0) ? 16'(-int'(lo)) : 16'(lo);
  endfunction

  function automatic tfn_pkg::out_t face_normal(tfn_pkg::in_t t);
    longint        ux, uy, uz, vx, vy, vz, nx, ny, nz;
    logic [127:0]  mx, my, mz;
    logic [127:0]  len_sq;
    tfn_pkg::out_t r;
    ux = longint'(t.b_x) - longint'(t.a_x);
    uy = longint'(t.b_y) - longint'(t.a_y);
    uz = longint'(t.b_z) - longint'(t.a_z);
    vx = longint'(t.c_x) - longint'(t.a_x);
    vy = longint'(t.c_y) - longint'(t.a_y);
    vz = longint'(t.c_z) - longint'(t.a_z);
    nx = uy * vz - uz * vy;
    ny = uz * vx - ux * vz;
    nz = ux * vy - uy * vx;
    r = '0;
    if (nx == 0 && ny == 0 && nz == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    mx = (nx < 0) ? 128'(-nx) : 128'(nx);
    my = (ny < 0) ? 128'(-ny) : 128'(ny);
    mz = (nz < 0) ? 128'(-nz) : 128'(nz);
    len_sq = mx * mx + my * my + mz * mz;
    r.normal_x = unit_component(nx, len_sq);
    r.normal_y = unit_component(ny, len_sq);
    r.normal_z = unit_component(nz, len_sq);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i) begin
    if ($urandom_range(0, 299) == 0) stall_quiet <= ~stall_quiet;
    if (!rst_ni || stall_quiet) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 30) begin
      out_stall_i <= 1'b1;
      stall_left  <= pick_gap();
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    tfn_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_normals.size() == 0) begin
        $error("unexpected transfer: %p", out_data_o);
        mismatch_count++;
      end else begin
        want = pending_normals.pop_front();
        if (out_data_o.normal_x !== want.normal_x) begin
          $error("normal_x expected %0d actual %0d", want.normal_x, out_data_o.normal_x);
          mismatch_count++;
        end
        if (out_data_o.normal_y !== want.normal_y) begin
          $error("normal_y expected %0d actual %0d", want.normal_y, out_data_o.normal_y);
          mismatch_count++;
        end
        if (out_data_o.normal_z !== want.normal_z) begin
          $error("normal_z expected %0d actual %0d", want.normal_z, out_data_o.normal_z);
          mismatch_count++;
        end
        if (out_data_o.degenerate !== want.degenerate) begin
          $error("degenerate expected %0b actual %0b", want.degenerate,
                 out_data_o.degenerate);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_triangle(tfn_pkg::in_t t);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (in_stall_o);
    pending_normals = {pending_normals, face_normal(t)};
    if ($urandom_range(0, 199) == 0) gap_quiet = ~gap_quiet;
    gap = gap_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic tfn_pkg::in_t make_triangle(int ax, int ay, int az, int bx, int by,
                                                 int bz, int cx, int cy, int cz);
    tfn_pkg::in_t t;
    t.a_x = 16'(ax); t.a_y = 16'(ay); t.a_z = 16'(az);
    t.b_x = 16'(bx); t.b_y = 16'(by); t.b_z = 16'(bz);
    t.c_x = 16'(cx); t.c_y = 16'(cy); t.c_z = 16'(cz);
    return t;
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  task automatic test_directed();
    send_triangle(make_triangle(0, 0, 0, 256, 0, 0, 0, 256, 0));
    send_triangle(make_triangle(0, 0, 0, 0, 256, 0, 256, 0, 0));
    send_triangle(make_triangle(0, 0, 0, 0, 256, 0, 0, 0, 256));
    send_triangle(make_triangle(0, 0, 0, 0, 0, 256, 256, 0, 0));
    send_triangle(make_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_triangle(make_triangle(5, 5, 5, 10, 10, 10, 20, 20, 20));
    send_triangle(make_triangle(1, 2, 3, 1, 2, 3, -7, 9, 4));
    send_triangle(make_triangle(-32768, -32768, -32768, 32767, 32767, 32767,
                                -32768, -32768, -32768));
    send_triangle(make_triangle(-32768, -32768, -32768, 32767, -32768, -32768,
                                -32768, 32767, -32768));
    send_triangle(make_triangle(32767, 32767, 32767, -32768, 32767, 32767,
                                32767, -32768, 32767));
    send_triangle(make_triangle(-32768, 32767, -32768, 32767, -32768, 32767,
                                32767, 32767, -32768));
    send_triangle(make_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0));
    send_triangle(make_triangle(0, 0, 0, 1, 1, 1, 1, -1, 0));
    send_triangle(make_triangle(0, 0, 0, 1, 0, 0, 1, 1, 1));
    send_triangle(make_triangle(-32768, 0, 0, 32767, 1, 0, 32767, 0, 1));
    send_triangle(make_triangle(100, -200, 300, 101, -200, 300, 100, -199, 300));
    send_triangle(make_triangle(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    send_triangle(make_triangle(0, 0, 0, 3, 4, 0, 0, 0, 5));
  endtask

  task automatic test_random(int unsigned count);
    int ax, ay, az, dx, dy, dz, t;
    repeat (count) begin
      ax = rand_coord(); ay = rand_coord(); az = rand_coord();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_triangle(make_triangle(ax, ay, az, rand_coord(), rand_coord(),
                                                rand_coord(), rand_coord(), rand_coord(),
                                                rand_coord()));
        4, 5: send_triangle(make_triangle(ax, ay, az,
                                          ax + int'($urandom_range(0, 8)) - 4,
                                          ay + int'($urandom_range(0, 8)) - 4,
                                          az + int'($urandom_range(0, 8)) - 4,
                                          ax + int'($urandom_range(0, 8)) - 4,
                                          ay + int'($urandom_range(0, 8)) - 4,
                                          az + int'($urandom_range(0, 8)) - 4));
        6, 7: begin
          dx = int'($urandom_range(0, 200)) - 100;
          dy = int'($urandom_range(0, 200)) - 100;
          dz = int'($urandom_range(0, 200)) - 100;
          t = int'($urandom_range(0, 6)) - 3;
          send_triangle(make_triangle(ax, ay, az, ax + dx, ay + dy, az + dz,
                                      ax + t * dx, ay + t * dy, az + t * dz));
        end
        8: send_triangle(make_triangle(ax, ay, az, ax, ay, az,
                                       rand_coord(), rand_coord(), rand_coord()));
        default: begin
          dx = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
          dy = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
          send_triangle(make_triangle(dx, dy, rand_coord(), -dx - 1, dy, rand_coord(),
                                      dx, -dy - 1, rand_coord()));
        end
      endcase
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1130);
    in_valid_i <= 1'b0;
    while (pending_normals.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
